[hdl/cde_pkg.sv]
// Shared constants, command codes and cell op, control and link types of the circular deque engine.
package cde_pkg;

	localparam int DEPTH      = 1024;
	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int CMD_W      = 3;
	localparam int CAP_W      = 11;
	localparam int VAL_W      = 32;

	localparam logic [CMD_W-1:0] CMD_INS_FRONT = CMD_W'(0);
	localparam logic [CMD_W-1:0] CMD_INS_REAR  = CMD_W'(1);
	localparam logic [CMD_W-1:0] CMD_DEL_FRONT = CMD_W'(2);
	localparam logic [CMD_W-1:0] CMD_DEL_REAR  = CMD_W'(3);

	typedef enum logic [2:0] {
		OP_NONE,
		OP_INS_FRONT,
		OP_INS_REAR,
		OP_DEL_FRONT,
		OP_DEL_REAR
	} cell_op_t;

	typedef struct packed {
		logic                  clr;
		cell_op_t              op;
		logic [DATA_WIDTH-1:0] din;
	} cell_ctrl_t;

	typedef struct packed {
		logic                  occ;
		logic [DATA_WIDTH-1:0] fwd;
		logic [DATA_WIDTH-1:0] rev;
	} cell_link_t;

endpackage

[hdl/circular_deque_engine.sv]
// Top level of the circular deque engine: cell row, entry count, capacity and result register.
// An accepted item's result waits in the first stage (pend_s1, ok_s1) and is then registered at the output.
// Throughput: one item per cycle while the input is not stalled; the whole cell row shifts or appends at once.
// Input stalls only while a result waits in the first stage behind a stalled output register.
// Reset empties the deque and sets capacity to 1024; entry contents are left undefined.
// A capacity write also empties the deque at once, with no clearing pass.
module circular_deque_engine import cde_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CAP_W-1:0]        cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [CMD_W-1:0]        command,
	input  logic signed [VAL_W-1:0] data_value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    accepted,
	output logic signed [VAL_W-1:0] front_value,
	output logic                    front_valid,
	output logic signed [VAL_W-1:0] rear_value,
	output logic                    rear_valid,
	output logic                    is_empty,
	output logic                    is_full
);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] cap_q;
	logic [CNT_W-1:0] cap_new;
	logic             pend_s1;
	logic             ok_s1;
	logic             out_valid_q;
	logic             accept_in;
	logic             advance;
	logic             has_room;
	logic             has_item;
	logic             ok;
	cell_op_t         op;
	cell_ctrl_t       ctrl;
	cell_link_t       head_link;
	cell_link_t       end_link;
	cell_link_t       links [DEPTH];

	logic                    accepted_q;
	logic signed [VAL_W-1:0] front_value_q;
	logic signed [VAL_W-1:0] rear_value_q;
	logic                    nonempty_q;
	logic                    is_full_q;

	assign advance   = pend_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = pend_s1 && out_valid_q && out_stall;
	assign accept_in = in_valid && !in_stall;
	assign has_room  = count_q < cap_q;
	assign has_item  = count_q != '0;

	always_comb begin
		op = OP_NONE;
		ok = 1'b1;
		unique case (command)
			CMD_INS_FRONT: begin
				ok = has_room;
				op = has_room ? OP_INS_FRONT : OP_NONE;
			end
			CMD_INS_REAR: begin
				ok = has_room;
				op = has_room ? OP_INS_REAR : OP_NONE;
			end
			CMD_DEL_FRONT: begin
				ok = has_item;
				op = has_item ? OP_DEL_FRONT : OP_NONE;
			end
			CMD_DEL_REAR: begin
				ok = has_item;
				op = has_item ? OP_DEL_REAR : OP_NONE;
			end
			default: begin
				ok = 1'b1;
				op = OP_NONE;
			end
		endcase
	end

	always_comb begin
		if (cfg_wdata == '0) begin
			cap_new = CNT_W'(1);
		end else if (32'(cfg_wdata) > 32'(DEPTH)) begin
			cap_new = CNT_W'(DEPTH);
		end else begin
			cap_new = CNT_W'(cfg_wdata);
		end
	end

	assign ctrl.clr = cfg_we;
	assign ctrl.op  = (accept_in && !cfg_we) ? op : OP_NONE;
	assign ctrl.din = DATA_WIDTH'($unsigned(data_value));

	assign head_link.occ = 1'b1;
	assign head_link.fwd = ctrl.din;
	assign head_link.rev = ctrl.din;
	assign end_link      = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_link_t left_link;
		cell_link_t right_link;
		if (i == 0) begin : g_first
			assign left_link = head_link;
		end else begin : g_mid
			assign left_link = links[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_link = end_link;
		end else begin : g_inner
			assign right_link = links[i+1];
		end
		cde_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.left   (left_link),
			.right  (right_link),
			.state  (links[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cap_q       <= CNT_W'(DEPTH);
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q   <= cap_new;
				count_q <= '0;
			end else if (ctrl.op == OP_INS_FRONT || ctrl.op == OP_INS_REAR) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctrl.op == OP_DEL_FRONT || ctrl.op == OP_DEL_REAR) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (accept_in) begin
				pend_s1 <= 1'b1;
			end else if (advance) begin
				pend_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			ok_s1 <= ok;
		end
		if (advance) begin
			accepted_q    <= ok_s1;
			nonempty_q    <= count_q != '0;
			is_full_q     <= count_q >= cap_q;
			front_value_q <= (count_q != '0) ? VAL_W'(links[0].fwd) : '0;
			rear_value_q  <= (count_q != '0) ? VAL_W'(links[0].rev) : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign accepted    = accepted_q;
	assign front_value = front_value_q;
	assign front_valid = nonempty_q;
	assign rear_value  = rear_value_q;
	assign rear_valid  = nonempty_q;
	assign is_empty    = !nonempty_q;
	assign is_full     = is_full_q;

endmodule

[hdl/cde_cell.sv]
// One slot of the deque cell row: occupancy bit plus front-first and rear-first entries.
module cde_cell import cde_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  cell_link_t left,
	input  cell_link_t right,
	output cell_link_t state
);

	logic                  occ_q;
	logic [DATA_WIDTH-1:0] fwd_q;
	logic [DATA_WIDTH-1:0] rev_q;
	logic                  tail_slot;

	// The first empty slot takes an item appended to the far end of either row.
	assign tail_slot = !occ_q && left.occ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctrl.clr) begin
			occ_q <= 1'b0;
		end else begin
			unique case (ctrl.op)
				OP_INS_FRONT, OP_INS_REAR: occ_q <= left.occ;
				OP_DEL_FRONT, OP_DEL_REAR: occ_q <= right.occ;
				default:                   occ_q <= occ_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_INS_FRONT: begin
				fwd_q <= left.fwd;
				if (tail_slot) begin
					rev_q <= ctrl.din;
				end
			end
			OP_INS_REAR: begin
				rev_q <= left.rev;
				if (tail_slot) begin
					fwd_q <= ctrl.din;
				end
			end
			OP_DEL_FRONT: fwd_q <= right.fwd;
			OP_DEL_REAR:  rev_q <= right.rev;
			default: begin
				fwd_q <= fwd_q;
				rev_q <= rev_q;
			end
		endcase
	end

	assign state.occ = occ_q;
	assign state.fwd = fwd_q;
	assign state.rev = rev_q;

endmodule
